// File: hdl/irx_pkg.sv
// Shared types and constants of the id range extent translator.
// Request/result payloads, extent record, sequencer states and ALU codes.
// No dependencies.
package irx_pkg;

  // Table depth and the widths that follow from it
  localparam int unsigned MaxExtents = 5;
  localparam int unsigned IdxW       = (MaxExtents > 1) ? $clog2(MaxExtents) : 1;
  localparam int unsigned CntW       = $clog2(MaxExtents + 1);

  localparam logic [31:0] NoId = 32'hFFFF_FFFF;

  // Configuration port: one register, selected by paddr[2]
  localparam int unsigned PaddrW        = 3;
  localparam logic        RegIdxExtents = 1'b0;

  typedef enum logic [1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_MAP_DOWN = 2'd1,
    FUNC_MAP_UP   = 2'd2
  } irx_func_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  slot;
    logic [31:0] inner_base;
    logic [31:0] outer_base;
    logic [31:0] span;
    logic [31:0] query_id;
    logic [31:0] query_len;
  } irx_req_t;

  typedef struct packed {
    logic [31:0] mapped_id;
    logic        found;
  } irx_res_t;

  typedef struct packed {
    logic [31:0] inner;
    logic [31:0] outer;
    logic [31:0] span;
  } irx_ext_t;

  typedef enum logic [1:0] {
    OP_LAST  = 2'd0,  // a + b - 1
    OP_SUB   = 2'd1,  // a - b
    OP_ADD   = 2'd2,  // a + b
    OP_RANGE = 2'd3   // b <= a <= c
  } irx_op_e;

  typedef struct packed {
    irx_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } irx_alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        in_range;
  } irx_alu_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QEND,
    ST_FETCH,
    ST_LAST,
    ST_CHK_ID,
    ST_CHK_END,
    ST_XLATE,
    ST_ADD
  } irx_state_e;

endpackage

// File: hdl/irx_table.sv
// Extent table: one write port, one read port with registered read data.
// Depends on irx_pkg.
module irx_table (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [irx_pkg::IdxW-1:0]      waddr_i,
  input  irx_pkg::irx_ext_t             wdata_i,
  input  logic [irx_pkg::IdxW-1:0]      raddr_i,
  output irx_pkg::irx_ext_t             rdata_o
);

  irx_pkg::irx_ext_t ext_mem [irx_pkg::MaxExtents];
  irx_pkg::irx_ext_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ext_mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= ext_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/irx_alu.sv
// Shared arithmetic unit: one 32-bit add/subtract or a two-sided range compare.
// Depends on irx_pkg.
module irx_alu (
  input  irx_pkg::irx_alu_req_t req_i,
  output irx_pkg::irx_alu_res_t res_o
);

  always_comb begin
    res_o.sum      = req_i.a;
    res_o.in_range = 1'b0;
    case (req_i.op)
      irx_pkg::OP_LAST:  res_o.sum = req_i.a + req_i.b - 32'd1;
      irx_pkg::OP_SUB:   res_o.sum = req_i.a - req_i.b;
      irx_pkg::OP_ADD:   res_o.sum = req_i.a + req_i.b;
      irx_pkg::OP_RANGE: res_o.in_range = (req_i.a >= req_i.b) && (req_i.a <= req_i.c);
      default:           res_o.sum = req_i.a;
    endcase
  end

endmodule

// File: hdl/id_range_extent_translator.sv
// Id range extent translator: top level with the scan sequencer and APB register.
// Depends on irx_pkg, irx_table and irx_alu.
//
// A write request loads one extent in the cycle it is accepted and leaves the
// block ready; a request with the unused function code is dropped the same way.
// A map request scans the extents from slot 0 upward with one shared 32-bit
// adder/comparator: it first forms the end of the query range, then per extent
// reads the table, forms the extent's last id and range-checks the query id
// (map down, when the id is in range, also checks the query end), and on a hit
// subtracts the first id and adds the other base. busy stays high throughout.
// The result appears on res_o with res_valid_o high for exactly one cycle and
// must be taken then; a new request may be started in that same cycle.
module id_range_extent_translator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  irx_pkg::irx_req_t               req_i,
  output logic                            res_valid_o,
  output irx_pkg::irx_res_t               res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [irx_pkg::PaddrW-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  irx_pkg::irx_state_e    state_q, state_d;
  logic [irx_pkg::CntW-1:0] idx_q, idx_d;
  logic [irx_pkg::CntW-1:0] scan_n;
  logic [irx_pkg::CntW-1:0] idx_inc;
  logic [3:0]             cfg_q;
  logic                   res_valid_q, res_valid_d;
  irx_pkg::irx_res_t      res_q, res_d;
  logic                   down_q;
  logic [31:0]            qid_q, qlen_q, qend_q, acc_q;
  logic [31:0]            qend_d, acc_d;

  logic                   accept;
  logic                   tbl_we;
  irx_pkg::irx_ext_t      tbl_wdata, tbl_rdata;
  logic [31:0]            ext_first, ext_other;
  irx_pkg::irx_alu_req_t  alu_req;
  irx_pkg::irx_alu_res_t  alu_res;
  logic                   cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == irx_pkg::RegIdxExtents);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      cfg_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == irx_pkg::RegIdxExtents) ? {28'd0, cfg_q} : 32'd0;

  // Clamp the scan count to the table depth
  always_comb begin
    if ({28'd0, cfg_q} > 32'(irx_pkg::MaxExtents)) begin
      scan_n = irx_pkg::CntW'(irx_pkg::MaxExtents);
    end else begin
      scan_n = irx_pkg::CntW'(cfg_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Extent table
  assign busy   = (state_q != irx_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign tbl_we = accept && (req_i.func == irx_pkg::FUNC_WRITE)
               && (32'(req_i.slot) < 32'(irx_pkg::MaxExtents));

  assign tbl_wdata.inner = req_i.inner_base;
  assign tbl_wdata.outer = req_i.outer_base;
  assign tbl_wdata.span  = req_i.span;

  irx_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (irx_pkg::IdxW'(req_i.slot)),
    .wdata_i (tbl_wdata),
    .raddr_i (idx_q[irx_pkg::IdxW-1:0]),
    .rdata_o (tbl_rdata)
  );

  assign ext_first = down_q ? tbl_rdata.inner : tbl_rdata.outer;
  assign ext_other = down_q ? tbl_rdata.outer : tbl_rdata.inner;

  irx_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign idx_inc = idx_q + irx_pkg::CntW'(1);

  // ---------------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    qend_d      = qend_q;
    acc_d       = acc_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    alu_req.op  = irx_pkg::OP_ADD;
    alu_req.a   = qid_q;
    alu_req.b   = ext_first;
    alu_req.c   = acc_q;

    case (state_q)
      irx_pkg::ST_IDLE: begin
        if (accept && ((req_i.func == irx_pkg::FUNC_MAP_DOWN)
                    || (req_i.func == irx_pkg::FUNC_MAP_UP))) begin
          state_d = irx_pkg::ST_QEND;
          idx_d   = '0;
        end
      end
      irx_pkg::ST_QEND: begin
        alu_req.op = irx_pkg::OP_LAST;
        alu_req.a  = qid_q;
        alu_req.b  = qlen_q;
        qend_d     = alu_res.sum;
        if (scan_n == '0) begin
          res_d.mapped_id = irx_pkg::NoId;
          res_d.found     = 1'b0;
          res_valid_d     = 1'b1;
          state_d         = irx_pkg::ST_IDLE;
        end else begin
          state_d = irx_pkg::ST_FETCH;
        end
      end
      irx_pkg::ST_FETCH: begin
        // read data for idx_q lands at the end of this cycle
        state_d = irx_pkg::ST_LAST;
      end
      irx_pkg::ST_LAST: begin
        alu_req.op = irx_pkg::OP_LAST;
        alu_req.a  = ext_first;
        alu_req.b  = tbl_rdata.span;
        acc_d      = alu_res.sum;
        state_d    = irx_pkg::ST_CHK_ID;
      end
      irx_pkg::ST_CHK_ID, irx_pkg::ST_CHK_END: begin
        alu_req.op = irx_pkg::OP_RANGE;
        alu_req.a  = (state_q == irx_pkg::ST_CHK_END) ? qend_q : qid_q;
        alu_req.b  = ext_first;
        alu_req.c  = acc_q;
        if (alu_res.in_range) begin
          state_d = (down_q && (state_q == irx_pkg::ST_CHK_ID)) ?
                    irx_pkg::ST_CHK_END : irx_pkg::ST_XLATE;
        end else if (idx_inc == scan_n) begin
          res_d.mapped_id = irx_pkg::NoId;
          res_d.found     = 1'b0;
          res_valid_d     = 1'b1;
          state_d         = irx_pkg::ST_IDLE;
        end else begin
          idx_d   = idx_inc;
          state_d = irx_pkg::ST_FETCH;
        end
      end
      irx_pkg::ST_XLATE: begin
        alu_req.op = irx_pkg::OP_SUB;
        alu_req.a  = qid_q;
        alu_req.b  = ext_first;
        acc_d      = alu_res.sum;
        state_d    = irx_pkg::ST_ADD;
      end
      irx_pkg::ST_ADD: begin
        alu_req.op      = irx_pkg::OP_ADD;
        alu_req.a       = acc_q;
        alu_req.b       = ext_other;
        res_d.mapped_id = alu_res.sum;
        res_d.found     = 1'b1;
        res_valid_d     = 1'b1;
        state_d         = irx_pkg::ST_IDLE;
      end
      default: begin
        state_d = irx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irx_pkg::ST_IDLE;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      down_q <= (req_i.func == irx_pkg::FUNC_MAP_DOWN);
      qid_q  <= req_i.query_id;
      qlen_q <= req_i.query_len;
    end
    qend_q <= qend_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while scan still running");

  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.found) |-> (res_o.mapped_id == irx_pkg::NoId))
    else $error("miss without all-ones id");

  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.func == irx_pkg::FUNC_WRITE)) |=> (!busy && !res_valid_o))
    else $error("extent write started a scan or gave a result");

endmodule

// File: tb/sv/extent_map_checker.sv
// Checker for the id range extent translator: watches the request, result and APB
// channels, keeps its own copy of the extent table and count, and compares results.
// Depends on irx_pkg.
`timescale 1ns / 100ps

module extent_map_checker
  import irx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  irx_req_t          req_i,
  input  logic              res_valid_i,
  input  irx_res_t          res_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic [31:0]       prdata_i,
  input  logic              pready_i,
  output int                mismatch_count_o,
  output int                pending_o,
  output int                results_o,
  output int                hits_o
);

  logic [31:0] inner_tab [MaxExtents];
  logic [31:0] outer_tab [MaxExtents];
  logic [31:0] span_tab  [MaxExtents];
  logic [3:0]  extents_cfg;
  irx_res_t    expected_ids_q [$];
  irx_res_t    want;
  int          mismatches;
  int          results_seen;
  int          hits_seen;

  // First in-use extent that holds the query; map down also needs the range end.
  function automatic irx_res_t translate_id(logic [1:0] func, logic [31:0] qid,
                                            logic [31:0] qlen);
    irx_res_t    res;
    logic [31:0] qend;
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] other;
    int unsigned n;
    res.mapped_id = NoId;
    res.found     = 1'b0;
    n    = (extents_cfg > MaxExtents) ? MaxExtents : extents_cfg;
    qend = qid + qlen - 32'd1;
    for (int i = 0; i < n; i++) begin
      first = (func == FUNC_MAP_DOWN) ? inner_tab[i] : outer_tab[i];
      other = (func == FUNC_MAP_DOWN) ? outer_tab[i] : inner_tab[i];
      last  = first + span_tab[i] - 32'd1;
      if (!res.found && qid >= first && qid <= last &&
          (func == FUNC_MAP_UP || (qend >= first && qend <= last))) begin
        res.mapped_id = qid - first + other;
        res.found     = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void report_mismatch(string what, logic [31:0] exp_val,
                                          logic [31:0] act_val);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
               $realtime, what, exp_val, act_val);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_ids_q.delete();
      extents_cfg      = '0;
      mismatches       = 0;
      results_seen     = 0;
      hits_seen        = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
      results_o        <= 0;
      hits_o           <= 0;
    end else begin
      // A result leaving at this edge belongs to an earlier request.
      if (res_valid_i) begin
        results_seen++;
        if (res_i.found) hits_seen++;
        if (expected_ids_q.size() == 0) begin
          report_mismatch("unexpected result (mapped_id)", NoId, res_i.mapped_id);
        end else begin
          want = expected_ids_q.pop_front();
          if (res_i.mapped_id !== want.mapped_id) begin
            report_mismatch("mapped_id", want.mapped_id, res_i.mapped_id);
          end
          if (res_i.found !== want.found) begin
            report_mismatch("found", 32'(want.found), 32'(res_i.found));
          end
        end
      end

      if (start_i && !busy_i) begin
        case (req_i.func)
          FUNC_WRITE: begin
            if (req_i.slot < MaxExtents) begin
              inner_tab[req_i.slot] = req_i.inner_base;
              outer_tab[req_i.slot] = req_i.outer_base;
              span_tab[req_i.slot]  = req_i.span;
            end
          end
          FUNC_MAP_DOWN, FUNC_MAP_UP: begin
            expected_ids_q.push_back(translate_id(req_i.func, req_i.query_id,
                                                  req_i.query_len));
          end
          default: ;
        endcase
      end

      if (psel_i && penable_i && pready_i && (paddr_i >> 2) == RegIdxExtents) begin
        if (pwrite_i) begin
          extents_cfg = pwdata_i[3:0];
        end else if (prdata_i[3:0] !== extents_cfg) begin
          report_mismatch("extents_in_use readback", 32'(extents_cfg), prdata_i);
        end
      end

      mismatch_count_o <= mismatches;
      pending_o        <= expected_ids_q.size();
      results_o        <= results_seen;
      hits_o           <= hits_seen;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top of the id range extent translator: clock, reset, request and APB
// stimulus, and the verdict. Depends on irx_pkg, the block and extent_map_checker.
`timescale 1ns / 100ps

module tb_top;
  import irx_pkg::*;

  localparam int          CycleLimit    = 500000;
  localparam int          DrainCycles   = 3 + 4 * MaxExtents + 8;
  localparam int          NumPhases     = 10;
  localparam int          ItemsPerPhase = 150;
  localparam logic [1:0]  FuncUnused    = 2'd3;
  localparam logic [PaddrW-1:0] ExtentsAddr = {RegIdxExtents, 2'b00};
  localparam logic [PaddrW-1:0] UnusedAddr  = {~RegIdxExtents, 2'b00};

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  irx_req_t          req_i;
  logic              res_valid_o;
  irx_res_t          res_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int          mismatch_count;
  int          pending;
  int          results;
  int          hits;
  int          accepted;
  int          settings;
  logic [31:0] sh_inner [MaxExtents];
  logic [31:0] sh_outer [MaxExtents];
  logic [31:0] sh_span  [MaxExtents];

  id_range_extent_translator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  extent_map_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req_i),
    .res_valid_i      (res_valid_o),
    .res_i            (res_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .results_o        (results),
    .hits_o           (hits)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles", CycleLimit);
    $display("Regression FAIL");
    $finish;
  end

  // Bases cluster near zero, the top of the id space and the signed boundary,
  // so extents overlap and wrap often.
  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 70);
      2:       return $urandom_range(0, 300);
      3:       return 32'h8000_0000 - $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic irx_req_t random_req(logic [1:0] func);
    irx_req_t r;
    r.func       = func;
    r.slot       = 3'($urandom_range(0, 7));
    r.inner_base = $urandom;
    r.outer_base = $urandom;
    r.span       = $urandom;
    r.query_id   = $urandom;
    r.query_len  = $urandom;
    return r;
  endfunction

  // Hold start high until the block takes the request.
  task automatic send_request(irx_req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    accepted++;
    if (r.func == FUNC_WRITE && r.slot < MaxExtents) begin
      sh_inner[r.slot] = r.inner_base;
      sh_outer[r.slot] = r.outer_base;
      sh_span[r.slot]  = r.span;
    end
  endtask

  task automatic write_extent(logic [2:0] slot, logic [31:0] inner, logic [31:0] outer,
                              logic [31:0] span);
    irx_req_t r;
    r            = random_req(FUNC_WRITE);
    r.slot       = slot;
    r.inner_base = inner;
    r.outer_base = outer;
    r.span       = span;
    send_request(r);
  endtask

  task automatic map_id(logic [1:0] func, logic [31:0] qid, logic [31:0] qlen);
    irx_req_t r;
    r           = random_req(func);
    r.query_id  = qid;
    r.query_len = qlen;
    send_request(r);
  endtask

  // Return with the bus idle so back-to-back calls start on a new edge.
  task automatic apb_access(logic wr, logic [PaddrW-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop start and let the scan finish before touching the register.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_extent_count(logic [3:0] count);
    wait_drained();
    apb_access(1'b1, ExtentsAddr, ($urandom & 32'hFFFF_FFF0) | 32'(count));
    apb_access(1'b0, ExtentsAddr, $urandom);
    settings++;
  endtask

  initial begin
    irx_req_t    r;
    int          sel;
    int          k;
    int          counted;
    int          stretch_left;
    bit          stretch_gappy;
    logic [31:0] first_id;
    logic [3:0]  phase_counts [NumPhases];

    phase_counts = '{4'd5, 4'd0, 4'd15, 4'd1, 4'd3, 4'd7, 4'd2, 4'd4, 4'd5, 4'd5};
    phase_counts[NumPhases - 2] = 4'($urandom_range(0, 15));
    clk_i    = 1'b0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    req_i    = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    accepted = 0;
    settings = 0;
    stretch_left  = 0;
    stretch_gappy = 1'b0;
    for (int i = 0; i < MaxExtents; i++) begin
      sh_inner[i] = '0;
      sh_outer[i] = '0;
      sh_span[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Count is zero after reset: every map misses without scanning.
    map_id(FUNC_MAP_DOWN, 32'd0, 32'd1);
    map_id(FUNC_MAP_UP, 32'hFFFF_FFFF, 32'd1);
    // Nearly full span, a wrapped extent, an empty one, the top end, a single id.
    write_extent(3'd0, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    write_extent(3'd1, 32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h0000_0020);
    write_extent(3'd2, 32'd100, 32'd200, 32'd0);
    write_extent(3'd3, 32'hFFFF_FF00, 32'h0000_0000, 32'h0000_0100);
    write_extent(3'd4, 32'h8000_0000, 32'h4000_0000, 32'd1);
    // Writes beyond the table and the unused function are dropped.
    write_extent(3'd7, 32'd1, 32'd2, 32'd3);
    write_extent(3'd5, 32'd1, 32'd2, 32'd3);
    send_request(random_req(FuncUnused));

    set_extent_count(4'd5);
    map_id(FUNC_MAP_DOWN, 32'd0, 32'd1);
    map_id(FUNC_MAP_DOWN, 32'hFFFF_FFFE, 32'd1);
    map_id(FUNC_MAP_DOWN, 32'hFFFF_FFFF, 32'd1);
    map_id(FUNC_MAP_DOWN, 32'd5, 32'd0);
    map_id(FUNC_MAP_DOWN, 32'd0, 32'd0);
    map_id(FUNC_MAP_DOWN, 32'hFFFF_FF80, 32'h0000_0080);
    map_id(FUNC_MAP_DOWN, 32'd0, 32'hFFFF_FFFF);
    map_id(FUNC_MAP_UP, 32'd0, 32'd1);
    map_id(FUNC_MAP_UP, 32'hFFFF_FFFF, 32'd1);
    map_id(FUNC_MAP_UP, 32'h4000_0000, 32'd1);

    // Counts above the depth scan the whole table.
    set_extent_count(4'd15);
    map_id(FUNC_MAP_UP, 32'h4000_0000, 32'd1);
    map_id(FUNC_MAP_DOWN, 32'h8000_0000, 32'd1);

    set_extent_count(4'd1);
    map_id(FUNC_MAP_DOWN, 32'hFFFF_FFFF, 32'd1);
    wait_drained();
    apb_access(1'b1, UnusedAddr, 32'hFFFF_FFFF);
    apb_access(1'b0, ExtentsAddr, 32'd0);
    map_id(FUNC_MAP_UP, 32'h0001_0000, 32'd1);

    for (int p = 0; p < NumPhases; p++) begin
      set_extent_count(phase_counts[p]);
      counted = 0;
      while (counted < ItemsPerPhase) begin
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, MaxExtents - 1);
        if (sel < 3) begin
          r = random_req(FuncUnused);
        end else if (sel < 18) begin
          r            = random_req(FUNC_WRITE);
          r.inner_base = pick_base();
          r.outer_base = pick_base();
          case ($urandom_range(0, 7))
            0:       r.span = 32'd0;
            1:       r.span = 32'd1;
            2:       r.span = 32'hFFFF_FFFF;
            3:       r.span = $urandom;
            4:       r.span = 32'h8000_0000;
            default: r.span = $urandom_range(1, 100);
          endcase
        end else begin
          r        = random_req((sel < 59) ? FUNC_MAP_DOWN : FUNC_MAP_UP);
          first_id = (r.func == FUNC_MAP_DOWN) ? sh_inner[k] : sh_outer[k];
          // Aim at the edges of a stored extent most of the time.
          case ($urandom_range(0, 4))
            0: r.query_id = first_id + $urandom_range(0, 2) - 32'd1;
            1: r.query_id = first_id + sh_span[k] - $urandom_range(0, 2);
            2: r.query_id = first_id + ((sh_span[k] == 0) ? 32'd0 : $urandom % sh_span[k]);
            3: r.query_id = $urandom;
            default: r.query_id = first_id + $urandom_range(0, 40);
          endcase
          sel = $urandom_range(0, 19);
          if (sel < 14)      r.query_len = 32'd1;
          else if (sel < 16) r.query_len = $urandom_range(0, 8);
          else if (sel < 18) r.query_len = $urandom_range(0, 64);
          else if (sel < 19) r.query_len = $urandom;
          else               r.query_len = sh_span[k];
        end
        if (r.func != FuncUnused && (r.func != FUNC_WRITE || r.slot < MaxExtents)) begin
          counted++;
        end
        send_request(r);

        if (stretch_left == 0) begin
          stretch_left  = $urandom_range(10, 60);
          stretch_gappy = ($urandom_range(0, 2) != 0);
        end
        stretch_left--;
        if (p < NumPhases - 1 && stretch_gappy && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
    end

    wait_drained();
    $display("Sent %0d requests over %0d extent-count settings", accepted, settings);
    $display("Checked %0d translations, %0d of them hits", results, hits);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
